FILE: src/bsc_pkg.sv
// shared widths and constants for the bhaskara sine/cosine pipeline
package bsc_pkg;

  // port widths of the angle and result words
  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 32;

  // default fixed-point scaling
  localparam int ANGLE_FRAC_BITS_DEF  = 28;
  localparam int RESULT_FRAC_BITS_DEF = 30;

  // pi scaled by 2^60, rounded to nearest
  localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

endpackage

FILE: src/bhaskara_sine_cosine.sv
// pipelined bhaskara sine/cosine approximation unit
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | in_mode (0 sine, 1 cosine), in_angle Q3.28
//  out      | out_valid/out_stall | out_value Q1.30, saturated to +/-1
//
// one word enters every cycle while in_stall is low; the depth is set by
// the two restoring subtract chains that run two steps per stage: the 2*pi
// range reduction and the quotient long division.
// rst_n clears only the stage valid bits and holds in_stall high; the
// datapath registers are not reset.
// out_stall holds the output register and bubbles in the pipe are squeezed
// out, so input is taken while a finished word waits, if any stage is empty.
module bhaskara_sine_cosine #(
  parameter int ANGLE_FRAC_BITS  = bsc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = bsc_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic signed [bsc_pkg::ANGLE_W-1:0]  in_angle,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bsc_pkg::VALUE_W-1:0]  out_value
);

  // scaled constants, worked out at elaboration
  localparam logic [63:0] PI64 =
    (bsc_pkg::PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] HALF64 =
    (bsc_pkg::PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] TWO64  = PI64 << 1;
  localparam logic [63:0] OFFS64 =
    ((64'd1 << (bsc_pkg::ANGLE_W - 1)) / TWO64 + 64'd1) * TWO64;
  localparam logic [63:0] C064   = OFFS64 + PI64;
  localparam logic [63:0] C0H64  = C064 + HALF64;
  localparam logic [63:0] K64    = 64'd5 * PI64 * PI64;
  localparam logic [63:0] SATY64 = (K64 + 64'd19) / 64'd20;

  // widths
  localparam int XW   = ANGLE_FRAC_BITS + 2;        // holds pi
  localparam int UW   = bsc_pkg::ANGLE_W + 3;       // offset angle
  localparam int QB   = UW - $clog2(TWO64);         // reduction quotient bits
  localparam int NRED = (QB + 1) / 2;               // reduction stages
  localparam int QBP  = 2 * NRED;
  localparam int YW   = 2 * XW;                     // x * (pi - x)
  localparam int DW   = YW + 2;                     // numerator / denominator
  localparam int QW   = RESULT_FRAC_BITS + 1;       // quotient plus round bit
  localparam int ND   = (QW + 1) / 2;               // division stages
  localparam int VW   = bsc_pkg::VALUE_W;

  // stage numbering
  localparam int S_F1  = NRED + 1;
  localparam int S_F2  = NRED + 2;
  localparam int S_MUL = NRED + 3;
  localparam int S_ND  = NRED + 4;
  localparam int S_RND = S_ND + ND + 1;
  localparam int S_OUT = S_RND + 1;
  localparam int NST   = S_OUT + 1;

  // sized constants
  localparam logic [UW-1:0] C0_U   = C064[UW-1:0];
  localparam logic [UW-1:0] C0H_U  = C0H64[UW-1:0];
  localparam logic [UW-1:0] D_U    = TWO64[UW-1:0];
  localparam logic [XW:0]   PI_X   = PI64[XW:0];
  localparam logic [XW-1:0] PI_W   = PI64[XW-1:0];
  localparam logic [XW-1:0] HALF_W = HALF64[XW-1:0];
  localparam logic [DW-1:0] K_D    = K64[DW-1:0];
  localparam logic [YW-1:0] SATY_Y = SATY64[YW-1:0];
  localparam logic [QW-1:0] ONE_Q  = {1'b1, {RESULT_FRAC_BITS{1'b0}}};

  // pipeline control
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_src;
  logic [NST-1:0] adv;

  // stage registers
  logic [UW-1:0] red_r   [NRED+1];
  logic [UW-1:0] red_nxt [NRED+1];
  logic          neg_f1_r, neg_f2_r, neg_mul_r;
  logic          neg_f1_nxt;
  logic [XW-1:0] mag_f1_r, mag_f1_nxt;
  logic [XW-1:0] x_f2_r, x_f2_nxt;
  logic [XW-1:0] rest_f2_r, rest_f2_nxt;
  logic [YW-1:0] y_mul_r, y_mul_nxt;
  logic [DW-1:0] rem_r   [ND+1];
  logic [DW-1:0] rem_nxt [ND+1];
  logic [QW-1:0] q_r     [ND+1];
  logic [QW-1:0] q_nxt   [ND+1];
  logic [DW-1:0] den_r   [ND+1];
  logic [DW-1:0] den_nxt [ND+1];
  logic          sat_r   [ND+1];
  logic          sat_nxt [ND+1];
  logic          neg_r   [ND+1];
  logic          neg_nxt [ND+1];
  logic [QW-1:0] mag_rnd_r, mag_rnd_nxt;
  logic          neg_rnd_r;
  logic [VW-1:0] out_value_r, out_value_nxt;

  // advance when a stage is empty or its successor moves
  always_comb begin
    adv[NST-1] = !v_r[NST-1] || !out_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign v_src    = {v_r[NST-2:0], in_valid};
  assign in_stall = !adv[0] || !rst_n;

  // offset the angle so it is positive, add pi/2 for cosine
  // then strip whole multiples of 2*pi, two restoring steps a stage
  always_comb begin
    logic [UW:0] t;
    logic [UW:0] dsh;
    red_nxt[0] = {{(UW - bsc_pkg::ANGLE_W){in_angle[bsc_pkg::ANGLE_W-1]}}, in_angle}
               + (in_mode ? C0H_U : C0_U);
    t   = '0;
    dsh = '0;
    for (int i = 1; i <= NRED; i++) begin
      t = {1'b0, red_r[i-1]};
      for (int k = 0; k < 2; k++) begin
        dsh = {1'b0, D_U} << (QBP - 2 * i + 1 - k);
        if (t >= dsh) begin
          t = t - dsh;
        end
      end
      red_nxt[i] = t[UW-1:0];
    end
  end

  // mirror around pi: sign and magnitude of the reduced angle
  always_comb begin
    logic [XW:0] rr;
    logic [XW:0] up;
    logic [XW:0] dn;
    rr         = red_r[NRED][XW:0];
    up         = rr - PI_X;
    dn         = PI_X - rr;
    neg_f1_nxt = rr < PI_X;
    mag_f1_nxt = neg_f1_nxt ? dn[XW-1:0] : up[XW-1:0];
  end

  // fold above pi/2 and form pi - x
  always_comb begin
    logic [XW-1:0] pm;
    logic          over;
    pm          = PI_W - mag_f1_r;
    over        = mag_f1_r > HALF_W;
    x_f2_nxt    = over ? pm : mag_f1_r;
    rest_f2_nxt = over ? mag_f1_r : pm;
  end

  // y = x * (pi - x)
  assign y_mul_nxt = {{XW{1'b0}}, x_f2_r} * {{XW{1'b0}}, rest_f2_r};

  // numerator, denominator and saturation, then the long division
  always_comb begin
    logic [DW-1:0] rem;
    logic [DW:0]   rem2;
    logic [QW-1:0] q;
    rem_nxt[0] = {y_mul_r[YW-3:0], 4'b0000};
    den_nxt[0] = K_D - {y_mul_r, 2'b00};
    sat_nxt[0] = y_mul_r >= SATY_Y;
    q_nxt[0]   = '0;
    neg_nxt[0] = neg_mul_r;
    rem  = '0;
    rem2 = '0;
    q    = '0;
    for (int s = 0; s < ND; s++) begin
      rem = rem_r[s];
      q   = q_r[s];
      for (int k = 0; k < 2; k++) begin
        if (2 * s + k < QW) begin
          rem2 = {rem, 1'b0};
          if (rem2 >= {1'b0, den_r[s]}) begin
            rem2 = rem2 - {1'b0, den_r[s]};
            q    = {q[QW-2:0], 1'b1};
          end else begin
            q    = {q[QW-2:0], 1'b0};
          end
          rem = rem2[DW-1:0];
        end
      end
      rem_nxt[s+1] = rem;
      q_nxt[s+1]   = q;
      den_nxt[s+1] = den_r[s];
      sat_nxt[s+1] = sat_r[s];
      neg_nxt[s+1] = neg_r[s];
    end
  end

  // round to nearest, saturate to one
  assign mag_rnd_nxt = sat_r[ND] ? ONE_Q
                     : ({1'b0, q_r[ND][QW-1:1]} + {{(QW-1){1'b0}}, q_r[ND][0]});

  // apply the sign
  always_comb begin
    logic [VW-1:0] ext;
    ext           = {{(VW - QW){1'b0}}, mag_rnd_r};
    out_value_nxt = neg_rnd_r ? (~ext + 1'b1) : ext;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_src[i];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    for (int i = 0; i <= NRED; i++) begin
      if (adv[i]) begin
        red_r[i] <= red_nxt[i];
      end
    end
    if (adv[S_F1]) begin
      neg_f1_r <= neg_f1_nxt;
      mag_f1_r <= mag_f1_nxt;
    end
    if (adv[S_F2]) begin
      neg_f2_r  <= neg_f1_r;
      x_f2_r    <= x_f2_nxt;
      rest_f2_r <= rest_f2_nxt;
    end
    if (adv[S_MUL]) begin
      neg_mul_r <= neg_f2_r;
      y_mul_r   <= y_mul_nxt;
    end
    for (int s = 0; s <= ND; s++) begin
      if (adv[S_ND + s]) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        den_r[s] <= den_nxt[s];
        sat_r[s] <= sat_nxt[s];
        neg_r[s] <= neg_nxt[s];
      end
    end
    if (adv[S_RND]) begin
      mag_rnd_r <= mag_rnd_nxt;
      neg_rnd_r <= neg_r[ND];
    end
    if (adv[S_OUT]) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = v_r[S_OUT];
  assign out_value = out_value_r;

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the bhaskara sine/cosine pipeline
`timescale 1ns / 1ps

module tb_top;

  localparam int AFB = bsc_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int RFB = bsc_pkg::RESULT_FRAC_BITS_DEF;

  // angle-scale constants, pi rounded to nearest at the angle scale
  localparam longint PI_FX      =
    longint'((bsc_pkg::PI_Q60 + (64'd1 << (59 - AFB))) >> (60 - AFB));
  localparam longint HALF_PI_FX =
    longint'((bsc_pkg::PI_Q60 + (64'd1 << (60 - AFB))) >> (61 - AFB));
  localparam longint TWO_PI_FX  = 2 * PI_FX;

  localparam logic MODE_SINE   = 1'b0;
  localparam logic MODE_COSINE = 1'b1;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_WAIT  = 80;
  localparam int REPORT_LIMIT = 10;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic                 in_mode   = MODE_SINE;
  logic signed [31:0]   in_angle  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   out_value;

  // predicted result words, oldest first
  logic [31:0] pending_values[$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  bit          tx_idle_on     = 1'b1;
  bit          rx_idle_on     = 1'b1;
  int          stall_left     = 0;
  logic [31:0] expected_value;

  bhaskara_sine_cosine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_mode),
    .in_angle  (in_angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // bhaskara rational approximation, bit exact at the default scaling
  function automatic logic [31:0] bhaskara_value(input logic cos_sel,
                                                 input logic signed [31:0] angle);
    longint          a;
    longint          k;
    bit              neg;
    longint unsigned x, rest, y, num, den, quo, rem, one, pi_u;
    int              i;
    a = longint'(angle);
    if (cos_sel) a += HALF_PI_FX;
    // whole turns of 2*pi in one step; exactly -pi is left alone
    if (a > PI_FX) begin
      k = (a - PI_FX + TWO_PI_FX - 1) / TWO_PI_FX;
      a -= k * TWO_PI_FX;
    end else if (a < -PI_FX) begin
      k = (-PI_FX - a + TWO_PI_FX - 1) / TWO_PI_FX;
      a += k * TWO_PI_FX;
    end
    // mirror negative half, fold upper quadrant
    neg = (a < 0);
    if (neg) a = -a;
    if (a > HALF_PI_FX) a = PI_FX - a;
    pi_u = longint'(PI_FX);
    x    = longint'(a);
    rest = longint'(PI_FX - a);
    y    = x * rest;
    num  = 16 * y;
    den  = 5 * pi_u * pi_u - 4 * y;
    one  = 64'd1 << RFB;
    // restoring division, round half up in magnitude, saturate at one
    if (den == 0 || num >= den) begin
      quo = one;
    end else begin
      quo = 0;
      rem = num;
      for (i = 0; i < RFB; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= den) begin
          rem -= den;
          quo |= 1;
        end
      end
      if ((rem << 1) >= den) quo += 1;
      if (quo > one) quo = one;
    end
    return neg ? (32'd0 - quo[31:0]) : quo[31:0];
  endfunction

  // gap length: mostly short, now and then long
  function automatic int pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // one word into the pipe; returns at the edge that takes it
  task automatic send_word(input logic mode, input logic [31:0] angle);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_angle <= angle;
    do @(posedge clk); while (in_stall);
    pending_values.push_back(bhaskara_value(mode, angle));
  endtask

  // stop sending and let every predicted word come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) @(posedge clk);
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_values.size() == 0) begin
        note_failure($sformatf("unexpected word value=%h", out_value));
      end else begin
        expected_value = pending_values.pop_front();
        if (out_value !== expected_value)
          note_failure($sformatf("value exp=%h got=%h", expected_value, out_value));
      end
    end
    if (!rx_idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // field extremes, pi and half-pi edges, wrap points, both modes
  task automatic test_directed_edges();
    longint edges[12];
    edges = '{0, 1, -1, 64'sh7FFF_FFFF, -64'sh8000_0000, PI_FX, -PI_FX,
              PI_FX + 1, -PI_FX - 1, HALF_PI_FX, HALF_PI_FX + 1, -HALF_PI_FX};
    foreach (edges[i]) begin
      send_word(MODE_SINE, edges[i][31:0]);
      send_word(MODE_COSINE, edges[i][31:0]);
    end
  endtask

  // any 32-bit angle, either mode
  task automatic test_random_full_range(input int count);
    repeat (count) send_word(1'($urandom_range(0, 1)), $urandom);
  endtask

  // small offsets around quadrant and turn boundaries
  task automatic test_near_boundaries(input int count);
    longint base;
    longint offset;
    repeat (count) begin
      case ($urandom_range(0, 4))
        0: base = 0;
        1: base = HALF_PI_FX;
        2: base = -HALF_PI_FX;
        3: base = PI_FX;
        default: base = -PI_FX;
      endcase
      base   += (longint'($urandom_range(0, 2)) - 1) * TWO_PI_FX;
      offset  = longint'($urandom_range(0, 512)) - 256;
      send_word(1'($urandom_range(0, 1)), 32'(base + offset));
    end
  endtask

  // full rate: no gaps on either side
  task automatic test_back_to_back(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_word(1'($urandom_range(0, 1)), $urandom);
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
  endtask

  // sender holds off until the pipe is empty, then resumes
  task automatic test_drain_pause();
    repeat (30) send_word(1'($urandom_range(0, 1)), $urandom);
    wait_drained();
    repeat (30) send_word(1'($urandom_range(0, 1)), $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_full_range(300);
    test_near_boundaries(350);
    test_back_to_back(250);
    test_drain_pause();
    test_random_full_range(150);
    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
